// ===== rtl/core/rcld_pkg.sv =====
// Package for the line decoder: shared types, keyword table and number helpers.
// Used by rcld_num_parse and rs485_command_line_decoder_core; depends on nothing.
`default_nettype none

package rcld_pkg;

   localparam int CNT_W = 32;

   // Keyword candidate bit positions.
   localparam int KW_REQ  = 0;
   localparam int KW_SET  = 1;
   localparam int KW_PING = 2;
   localparam int KW_GET  = 3;
   localparam int KW_LOCK = 4;
   localparam int KW_NUM  = 5;
   // Flag bit telling that field 0 held at least one character.
   localparam int F0_NONEMPTY = 7;

   localparam logic [KW_NUM-1:0] KW_ALL = '1;

   // Field length saturates here; every keyword is shorter.
   localparam logic [2:0] LEN_SAT = 3'd7;

   // Number accumulator saturates at this value, which never matches.
   localparam logic [8:0] NUM_TOO_BIG = 9'd256;

   localparam logic [7:0] CHR_CR    = 8'd13;
   localparam logic [7:0] CHR_LF    = 8'd10;
   localparam logic [7:0] CHR_NUL   = 8'd0;
   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'd9;
   localparam logic [7:0] CHR_VT    = 8'd11;
   localparam logic [7:0] CHR_FF    = 8'd12;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_PING = 2'd1;
   localparam logic [1:0] ACT_POLL = 2'd2;
   localparam logic [1:0] ACT_LOCK = 2'd3;

   localparam logic [7:0] CSR_NODE_ADDRESS  = 8'd0;
   localparam logic [7:0] CSR_SERVO_PRESENT = 8'd1;

   // Keyword text, one row per keyword, unused positions zero.
   localparam logic [7:0] KW_TEXT [KW_NUM][4] = '{
      '{8'h52, 8'h45, 8'h51, 8'h00},   // REQ
      '{8'h53, 8'h45, 8'h54, 8'h00},   // SET
      '{8'h50, 8'h49, 8'h4E, 8'h47},   // PING
      '{8'h47, 8'h45, 8'h54, 8'h00},   // GET
      '{8'h4C, 8'h4F, 8'h43, 8'h4B}    // LOCK
   };
   localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd3, 3'd4, 3'd3, 3'd4};

   typedef struct packed {
      logic bad;
      logic digit;
      logic sign;
      logic neg;
   } num_status_type;

   typedef struct packed {
      num_status_type status;
      logic [8:0]     acc;
   } num_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } num_value_type;

   // Final value of a number field: invalid, too large or negative non-zero
   // numbers come back not valid; minus zero is zero.
   function automatic num_value_type num_value(input num_state_type ns);
      num_value_type r;
      r.value = ns.acc[7:0];
      r.valid = ns.status.digit && !ns.status.bad && (ns.acc < NUM_TOO_BIG) &&
                ((ns.acc == 9'd0) || !ns.status.neg);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rs485_command_line_decoder_core.sv =====
// Top level of the bus node command-line decoder.
// Depends on rcld_pkg and instantiates rcld_num_parse twice.
`default_nettype none

// The decoder takes one received byte per request and frames the bytes into
// lines ended by CR or LF. Each finished non-empty line yields exactly one
// response carrying the decoded action (ping reply, sensor poll or set lock),
// the reply slot delay for a broadcast ping, the requested lock state and the
// four event counters; other bytes yield no response. A byte is first held in
// an input register and is then decoded into the line state and the response
// register, so one byte per clock is accepted while no response waits, and the
// response to a terminator is registered when the held terminator moves on.
// While a response waits to be taken the held byte cannot move on, so the
// input register takes at most one more byte and then stalls until the
// response is taken. The
// line is never stored: keywords are tracked as candidate bits and the two
// numeric fields (the address and the lock value) are accumulated as they
// arrive. Configuration writes are always taken at once and should only be
// issued while no byte is in flight.

module rs485_command_line_decoder_core #(
   parameter int LINE_CAPACITY = 128,
   parameter int MAX_FIELDS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_rx_byte,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_action,
   output      logic [7:0]  rsp_reply_delay_slots,
   output      logic        rsp_lock_state,
   output      logic [31:0] rsp_byte_count,
   output      logic [31:0] rsp_line_count,
   output      logic [31:0] rsp_command_count,
   output      logic [31:0] rsp_overflow_count,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int POS_W = $clog2(LINE_CAPACITY);
   localparam int FI_W  = $clog2(MAX_FIELDS + 1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_CAPACITY - 1);
   localparam logic [FI_W-1:0]  FI_MAX   = FI_W'(MAX_FIELDS);

   localparam int CW = rcld_pkg::CNT_W;

   // Configuration registers.
   logic [7:0] node_address_ff;
   logic       servo_present_ff;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Line decoding state.
   logic [POS_W-1:0]            line_pos_ff, line_pos_in;
   logic [FI_W-1:0]             field_idx_ff, field_idx_in;
   logic [2:0]                  field_len_ff, field_len_in;
   logic [rcld_pkg::KW_NUM-1:0] cand_ff, cand_in;
   logic [7:0]                  flags_ff, flags_in;
   rcld_pkg::num_state_type     num0_ff, num0_in, num1_ff, num1_in;
   rcld_pkg::num_state_type     num0_step, num1_step;
   logic                        nul_ff, nul_in;

   // Event counters.
   logic [CW-1:0] byte_cnt_ff, byte_cnt_in;
   logic [CW-1:0] line_cnt_ff, line_cnt_in;
   logic [CW-1:0] cmd_cnt_ff, cmd_cnt_in;
   logic [CW-1:0] ovf_cnt_ff, ovf_cnt_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  action_ff, action_in;
   logic [7:0]  delay_ff, delay_in;
   logic        lock_ff, lock_in;

   logic       advance;
   logic       is_term;
   logic [rcld_pkg::KW_NUM-1:0] exact;
   logic [rcld_pkg::KW_NUM-1:0] char_ok;
   logic [7:0] commit_bits;
   logic [7:0] flags_done;
   rcld_pkg::num_value_type n1, n3;
   logic       n1_for_us;

   // The held byte moves on whenever the response register is free or is
   // being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign is_term   = (in_byte_ff == rcld_pkg::CHR_CR) || (in_byte_ff == rcld_pkg::CHR_LF);

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   // Keyword tracking: a candidate survives while its text matches so far,
   // and matches exactly when the field ends at its length.
   always_comb begin
      for (int k = 0; k < rcld_pkg::KW_NUM; k++) begin
         exact[k]   = cand_ff[k] && (field_len_ff == rcld_pkg::KW_LEN[k]);
         char_ok[k] = (field_len_ff < rcld_pkg::KW_LEN[k]) &&
                      (rcld_pkg::KW_TEXT[k][field_len_ff[1:0]] == in_byte_ff);
      end
   end

   // Flags that closing the current field would add.
   always_comb begin
      commit_bits = '0;
      if (field_idx_ff == FI_W'(0)) begin
         commit_bits[rcld_pkg::KW_REQ]      = exact[rcld_pkg::KW_REQ];
         commit_bits[rcld_pkg::KW_SET]      = exact[rcld_pkg::KW_SET];
         commit_bits[rcld_pkg::F0_NONEMPTY] = (field_len_ff != 3'd0);
      end else if (field_idx_ff == FI_W'(2)) begin
         commit_bits[rcld_pkg::KW_PING] = exact[rcld_pkg::KW_PING];
         commit_bits[rcld_pkg::KW_GET]  = exact[rcld_pkg::KW_GET];
         commit_bits[rcld_pkg::KW_LOCK] = exact[rcld_pkg::KW_LOCK];
      end
   end

   // At a line end the last field is closed unless the field limit was hit.
   assign flags_done = (field_idx_ff < FI_MAX) ? (flags_ff | commit_bits) : flags_ff;

   rcld_num_parse u_num_addr (
      .chr (in_byte_ff),
      .cur (num0_ff),
      .nxt (num0_step)
   );

   rcld_num_parse u_num_lock (
      .chr (in_byte_ff),
      .cur (num1_ff),
      .nxt (num1_step)
   );

   assign n1 = rcld_pkg::num_value(num0_ff);
   assign n3 = rcld_pkg::num_value(num1_ff);
   assign n1_for_us = n1.valid && ((n1.value == node_address_ff) || (n1.value == 8'd0));

   // Action decode for a finished line.
   always_comb begin
      action_in = rcld_pkg::ACT_NONE;
      delay_in  = 8'd0;
      lock_in   = 1'b0;
      if (flags_done[rcld_pkg::KW_REQ] && n1_for_us) begin
         if (flags_done[rcld_pkg::KW_PING]) begin
            action_in = rcld_pkg::ACT_PING;
            // A broadcast ping answers in the slot given by this node's address.
            if ((n1.value == 8'd0) && (node_address_ff != 8'd0)) begin
               delay_in = node_address_ff - 8'd1;
            end
         end else if (flags_done[rcld_pkg::KW_GET] && (n1.value != 8'd0)) begin
            action_in = rcld_pkg::ACT_POLL;
         end
      end else if (flags_done[rcld_pkg::KW_SET] && n1.valid &&
                   (n1.value == node_address_ff) && flags_done[rcld_pkg::KW_LOCK]) begin
         if (n3.valid && (n3.value[7:1] == 7'd0) && servo_present_ff) begin
            action_in = rcld_pkg::ACT_LOCK;
            lock_in   = n3.value[0];
         end
      end
   end

   // Line state and counter update for the held byte.
   always_comb begin
      line_pos_in  = line_pos_ff;
      field_idx_in = field_idx_ff;
      field_len_in = field_len_ff;
      cand_in      = cand_ff;
      flags_in     = flags_ff;
      num0_in      = num0_ff;
      num1_in      = num1_ff;
      nul_in       = nul_ff;
      byte_cnt_in  = byte_cnt_ff;
      line_cnt_in  = line_cnt_ff;
      cmd_cnt_in   = cmd_cnt_ff;
      ovf_cnt_in   = ovf_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (advance) begin
         byte_cnt_in = byte_cnt_ff + CW'(1);
         if (!is_term) begin
            if (line_pos_ff >= POS_LAST) begin
               // Overlong line: drop the byte and restart the line empty.
               ovf_cnt_in   = ovf_cnt_ff + CW'(1);
               line_pos_in  = '0;
               field_idx_in = '0;
               field_len_in = '0;
               cand_in      = rcld_pkg::KW_ALL;
               flags_in     = '0;
               num0_in      = '0;
               num1_in      = '0;
               nul_in       = 1'b0;
            end else begin
               line_pos_in = line_pos_ff + POS_W'(1);
               if (!nul_ff && (field_idx_ff < FI_MAX)) begin
                  if (in_byte_ff == rcld_pkg::CHR_NUL) begin
                     nul_in = 1'b1;
                  end else if (in_byte_ff == rcld_pkg::CHR_COMMA) begin
                     flags_in     = flags_ff | commit_bits;
                     field_idx_in = field_idx_ff + FI_W'(1);
                     field_len_in = '0;
                     cand_in      = rcld_pkg::KW_ALL;
                  end else begin
                     if ((field_idx_ff == FI_W'(0)) || (field_idx_ff == FI_W'(2))) begin
                        cand_in = cand_ff & char_ok;
                     end
                     if (field_idx_ff == FI_W'(1)) begin
                        num0_in = num0_step;
                     end
                     if (field_idx_ff == FI_W'(3)) begin
                        num1_in = num1_step;
                     end
                     if (field_len_ff != rcld_pkg::LEN_SAT) begin
                        field_len_in = field_len_ff + 3'd1;
                     end
                  end
               end
            end
         end else if (line_pos_ff != '0) begin
            // A finished non-empty line: report and start over.
            rsp_valid_in = 1'b1;
            line_cnt_in  = line_cnt_ff + CW'(1);
            if (flags_done[rcld_pkg::F0_NONEMPTY]) begin
               cmd_cnt_in = cmd_cnt_ff + CW'(1);
            end
            line_pos_in  = '0;
            field_idx_in = '0;
            field_len_in = '0;
            cand_in      = rcld_pkg::KW_ALL;
            flags_in     = '0;
            num0_in      = '0;
            num1_in      = '0;
            nul_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff  <= 8'd1;
         servo_present_ff <= 1'b1;
         in_valid_ff      <= 1'b0;
         line_pos_ff      <= '0;
         field_idx_ff     <= '0;
         field_len_ff     <= '0;
         cand_ff          <= rcld_pkg::KW_ALL;
         flags_ff         <= '0;
         num0_ff          <= '0;
         num1_ff          <= '0;
         nul_ff           <= 1'b0;
         byte_cnt_ff      <= '0;
         line_cnt_ff      <= '0;
         cmd_cnt_ff       <= '0;
         ovf_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == rcld_pkg::CSR_NODE_ADDRESS) begin
               node_address_ff <= csr_wdata;
            end else if (csr_index == rcld_pkg::CSR_SERVO_PRESENT) begin
               servo_present_ff <= csr_wdata[0];
            end
         end
         in_valid_ff  <= in_valid_in;
         line_pos_ff  <= line_pos_in;
         field_idx_ff <= field_idx_in;
         field_len_ff <= field_len_in;
         cand_ff      <= cand_in;
         flags_ff     <= flags_in;
         num0_ff      <= num0_in;
         num1_ff      <= num1_in;
         nul_ff       <= nul_in;
         byte_cnt_ff  <= byte_cnt_in;
         line_cnt_ff  <= line_cnt_in;
         cmd_cnt_ff   <= cmd_cnt_in;
         ovf_cnt_ff   <= ovf_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && is_term && (line_pos_ff != '0)) begin
         action_ff <= action_in;
         delay_ff  <= delay_in;
         lock_ff   <= lock_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_action            = action_ff;
   assign rsp_reply_delay_slots = delay_ff;
   assign rsp_lock_state        = lock_ff;
   // The counters only change on an advance, which cannot overwrite a waiting
   // response, so their registers double as the response payload.
   assign rsp_byte_count        = byte_cnt_ff;
   assign rsp_line_count        = line_cnt_ff;
   assign rsp_command_count     = cmd_cnt_ff;
   assign rsp_overflow_count    = ovf_cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rcld_num_parse.sv =====
// One character step of the decimal number parser for a single number field.
// Depends on rcld_pkg for the parser state types and character codes.
`default_nettype none

module rcld_num_parse (
   input  wire logic [7:0]            chr,
   input  wire rcld_pkg::num_state_type cur,
   output rcld_pkg::num_state_type    nxt
);

   logic        is_digit;
   logic        is_blank;
   logic        is_sign;
   logic        started;
   logic [12:0] prod;

   assign is_digit = (chr >= rcld_pkg::CHR_ZERO) && (chr <= rcld_pkg::CHR_NINE);
   assign is_blank = (chr == rcld_pkg::CHR_SPACE) || (chr == rcld_pkg::CHR_TAB) ||
                     (chr == rcld_pkg::CHR_VT) || (chr == rcld_pkg::CHR_FF);
   assign is_sign  = (chr == rcld_pkg::CHR_PLUS) || (chr == rcld_pkg::CHR_MINUS);
   assign started  = cur.status.sign || cur.status.digit;

   // acc * 10 + digit, the accumulator never exceeds 256.
   assign prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} +
                 {9'd0, chr[3:0] - rcld_pkg::CHR_ZERO[3:0]};

   always_comb begin
      nxt = cur;
      if (!cur.status.bad) begin
         if (is_digit) begin
            nxt.status.digit = 1'b1;
            if (prod > {4'd0, rcld_pkg::NUM_TOO_BIG}) begin
               nxt.acc = rcld_pkg::NUM_TOO_BIG;
            end else begin
               nxt.acc = prod[8:0];
            end
         end else if (is_blank && !started) begin
            nxt = cur;
         end else if (is_sign && !started) begin
            nxt.status.sign = 1'b1;
            nxt.status.neg  = (chr == rcld_pkg::CHR_MINUS);
         end else begin
            nxt.status.bad = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== bench/rs485_command_line_decoder_core_tb.sv =====
// Self-checking bench for rs485_command_line_decoder_core: directed command lines, then random
// command lines, noise and overlong lines under several register settings.
// Depends on rcld_pkg and the core RTL; the line decoder is predicted by a scoreboard class.
module rs485_command_line_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CAP      = 128;
   localparam int FIELD_CAP     = 8;
   localparam int KWN           = rcld_pkg::KW_NUM;
   // Idle time in settle() after the last response, so a held byte can pass through.
   localparam int SETTLE_CYCLES = 8;

   // Indexes into the event counter array.
   localparam int CNT_BYTES = 0;
   localparam int CNT_LINES = 1;
   localparam int CNT_CMDS  = 2;
   localparam int CNT_OVF   = 3;

   // Keywords that may close field 0 and field 2.
   localparam logic [KWN-1:0] HEAD_KEYWORDS =
      KWN'((1 << rcld_pkg::KW_REQ) | (1 << rcld_pkg::KW_SET));
   localparam logic [KWN-1:0] TAIL_KEYWORDS =
      KWN'((1 << rcld_pkg::KW_PING) | (1 << rcld_pkg::KW_GET) | (1 << rcld_pkg::KW_LOCK));

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  delay;
      logic        lock;
      logic [31:0] bytes;
      logic [31:0] lines;
      logic [31:0] commands;
      logic [31:0] overflows;
   } line_result_type;

   typedef struct {
      logic neg;
      logic sign;
      logic digit;
      logic bad;
      int   acc;
   } num_track_type;

   // Tracks the line decoder byte by byte and holds the responses that the
   // finished lines must produce, oldest first.
   class line_scoreboard;
      logic [7:0]        node_addr;
      logic              servo_on;
      int                line_pos;
      int                field_idx;
      int                field_len;
      logic [KWN-1:0]    cands;
      logic [7:0]        kw_flags;
      num_track_type     nums[2];
      logic              nul_seen;
      logic [31:0]       counts[4];
      line_result_type   expected_lines[$];
      int                failures;

      function new();
         node_addr = 8'd1;
         servo_on  = 1'b1;
         foreach (counts[i]) counts[i] = '0;
         failures = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_pos  = 0;
         field_idx = 0;
         field_len = 0;
         cands     = '1;
         kw_flags  = '0;
         nul_seen  = 1'b0;
         foreach (nums[i]) nums[i] = '{neg: 1'b0, sign: 1'b0, digit: 1'b0, bad: 1'b0, acc: 0};
      endfunction

      function void set_register(logic [7:0] index, logic [7:0] value);
         if (index == rcld_pkg::CSR_NODE_ADDRESS)
            node_addr = value;
         else if (index == rcld_pkg::CSR_SERVO_PRESENT)
            servo_on = value[0];
      endfunction

      function string kw_text(int k);
         case (k)
            rcld_pkg::KW_REQ:  return "REQ";
            rcld_pkg::KW_SET:  return "SET";
            rcld_pkg::KW_PING: return "PING";
            rcld_pkg::KW_GET:  return "GET";
            default:           return "LOCK";
         endcase
      endfunction

      function logic [KWN-1:0] exact_matches(logic [KWN-1:0] mask);
         logic [KWN-1:0] got;
         got = '0;
         for (int k = 0; k < KWN; k++)
            if (mask[k] && cands[k] && field_len == kw_text(k).len())
               got[k] = 1'b1;
         return got;
      endfunction

      function void commit_field();
         if (field_idx == 0) begin
            kw_flags[KWN-1:0] |= exact_matches(HEAD_KEYWORDS);
            if (field_len > 0)
               kw_flags[rcld_pkg::F0_NONEMPTY] = 1'b1;
         end else if (field_idx == 2) begin
            kw_flags[KWN-1:0] |= exact_matches(TAIL_KEYWORDS);
         end
      endfunction

      function void keyword_char(logic [7:0] c);
         for (int k = 0; k < KWN; k++)
            if (cands[k] && (field_len >= kw_text(k).len() ||
                             8'(kw_text(k).getc(field_len)) != c))
               cands[k] = 1'b0;
      endfunction

      function void number_char(int slot, logic [7:0] c);
         if (nums[slot].bad)
            return;
         if (c >= rcld_pkg::CHR_ZERO && c <= rcld_pkg::CHR_NINE) begin
            nums[slot].acc = nums[slot].acc * 10 + int'(c - rcld_pkg::CHR_ZERO);
            if (nums[slot].acc > int'(rcld_pkg::NUM_TOO_BIG))
               nums[slot].acc = int'(rcld_pkg::NUM_TOO_BIG);
            nums[slot].digit = 1'b1;
         end else if ((c == rcld_pkg::CHR_SPACE || c == rcld_pkg::CHR_TAB ||
                       c == rcld_pkg::CHR_VT || c == rcld_pkg::CHR_FF) &&
                      !(nums[slot].sign || nums[slot].digit)) begin
            // Leading blanks are skipped.
         end else if ((c == rcld_pkg::CHR_PLUS || c == rcld_pkg::CHR_MINUS) &&
                      !(nums[slot].sign || nums[slot].digit)) begin
            nums[slot].sign = 1'b1;
            if (c == rcld_pkg::CHR_MINUS)
               nums[slot].neg = 1'b1;
         end else begin
            nums[slot].bad = 1'b1;
         end
      endfunction

      // Returns -1 for a number that can never match, else its value.
      function int number_value(int slot);
         if (!nums[slot].digit || nums[slot].bad ||
             nums[slot].acc >= int'(rcld_pkg::NUM_TOO_BIG))
            return -1;
         if (nums[slot].acc == 0)
            return 0;
         if (nums[slot].neg)
            return -1;
         return nums[slot].acc;
      endfunction

      function void content_byte(logic [7:0] c);
         if (nul_seen || field_idx >= FIELD_CAP)
            return;
         if (c == rcld_pkg::CHR_NUL) begin
            nul_seen = 1'b1;
            return;
         end
         if (c == rcld_pkg::CHR_COMMA) begin
            commit_field();
            field_idx++;
            field_len = 0;
            cands     = '1;
            return;
         end
         if (field_idx == 0 || field_idx == 2)
            keyword_char(c);
         else if (field_idx == 1)
            number_char(0, c);
         else if (field_idx == 3)
            number_char(1, c);
         if (field_len < 255)
            field_len++;
      endfunction

      function void note_byte(logic [7:0] c);
         line_result_type r;
         int              n1;
         int              n3;
         counts[CNT_BYTES]++;
         if (c != rcld_pkg::CHR_CR && c != rcld_pkg::CHR_LF) begin
            if (line_pos >= LINE_CAP - 1) begin
               counts[CNT_OVF]++;
               clear_line();
            end else begin
               line_pos++;
               content_byte(c);
            end
            return;
         end
         if (line_pos == 0)
            return;
         if (field_idx < FIELD_CAP)
            commit_field();
         counts[CNT_LINES]++;
         if (kw_flags[rcld_pkg::F0_NONEMPTY])
            counts[CNT_CMDS]++;
         r        = '0;
         r.action = rcld_pkg::ACT_NONE;
         n1       = number_value(0);
         if (kw_flags[rcld_pkg::KW_REQ] && n1 >= 0 &&
             (n1 == int'(node_addr) || n1 == 0)) begin
            if (kw_flags[rcld_pkg::KW_PING]) begin
               r.action = rcld_pkg::ACT_PING;
               if (n1 == 0 && node_addr > 0)
                  r.delay = node_addr - 8'd1;
            end else if (kw_flags[rcld_pkg::KW_GET] && n1 != 0) begin
               r.action = rcld_pkg::ACT_POLL;
            end
         end else if (kw_flags[rcld_pkg::KW_SET] && n1 >= 0 && n1 == int'(node_addr) &&
                      kw_flags[rcld_pkg::KW_LOCK]) begin
            n3 = number_value(1);
            if ((n3 == 0 || n3 == 1) && servo_on) begin
               r.action = rcld_pkg::ACT_LOCK;
               r.lock   = n3[0];
            end
         end
         r.bytes     = counts[CNT_BYTES];
         r.lines     = counts[CNT_LINES];
         r.commands  = counts[CNT_CMDS];
         r.overflows = counts[CNT_OVF];
         expected_lines.push_back(r);
         clear_line();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(line_result_type got);
         line_result_type want;
         if (expected_lines.size() == 0) begin
            $error("response with no finished line waiting");
            failures++;
            return;
         end
         want = expected_lines.pop_front();
         compare_field("action", 32'(want.action), 32'(got.action));
         compare_field("reply_delay_slots", 32'(want.delay), 32'(got.delay));
         compare_field("lock_state", 32'(want.lock), 32'(got.lock));
         compare_field("byte_count", want.bytes, got.bytes);
         compare_field("line_count", want.lines, got.lines);
         compare_field("command_count", want.commands, got.commands);
         compare_field("overflow_count", want.overflows, got.overflows);
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [1:0]  rsp_action;
   logic [7:0]  rsp_reply_delay_slots;
   logic        rsp_lock_state;
   logic [31:0] rsp_byte_count;
   logic [31:0] rsp_line_count;
   logic [31:0] rsp_command_count;
   logic [31:0] rsp_overflow_count;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index   = 8'd0;
   logic [7:0]  csr_wdata   = 8'd0;

   line_scoreboard book = new();

   // When clear, neither side of the bench inserts idle cycles.
   logic        idle_on    = 1'b1;
   int          bytes_sent = 0;
   // Bytes of the line being assembled for sending.
   logic [7:0]  line_buf[$];

   rs485_command_line_decoder_core #(
      .LINE_CAPACITY(LINE_CAP),
      .MAX_FIELDS   (FIELD_CAP)
   ) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_action           (rsp_action),
      .rsp_reply_delay_slots(rsp_reply_delay_slots),
      .rsp_lock_state       (rsp_lock_state),
      .rsp_byte_count       (rsp_byte_count),
      .rsp_line_count       (rsp_line_count),
      .rsp_command_count    (rsp_command_count),
      .rsp_overflow_count   (rsp_overflow_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The response side stalls on about a third of the cycles while idling is on.
   always @(negedge clock) begin
      rsp_ready = idle_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
   end

   // Every response taken at a rising edge is checked against the oldest finished line.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_result(line_result_type'{rsp_action, rsp_reply_delay_slots,
                                             rsp_lock_state, rsp_byte_count, rsp_line_count,
                                             rsp_command_count, rsp_overflow_count});
   end

   // Offers one byte as a request. Valid only drops on an idle cycle, so a
   // run of back-to-back requests keeps valid high across the bytes.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 33) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (!req_ready);
      book.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      line_buf.delete();
   endtask

   // Register writes happen only with the decoder drained, so the expected
   // responses never straddle a change of node address or servo presence.
   task automatic write_register(input logic [7:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      book.set_register(index, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Stops offering bytes, waits for every response, then lets a byte that
   // ends no line work its way through before anything else happens.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void push_byte(input logic [7:0] b);
      line_buf.push_back(b);
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(8'(s.getc(i)));
   endfunction

   function automatic void end_line();
      push_byte($urandom_range(0, 1) ? rcld_pkg::CHR_CR : rcld_pkg::CHR_LF);
   endfunction

   // A directed line: the text and one terminator.
   task automatic send_text_line(input string s);
      push_text(s);
      end_line();
      send_line();
   endtask

   // Address field text, mostly the given target and sometimes a near miss.
   function automatic string addr_text(input int target);
      case ($urandom_range(0, 19))
         10:      return $sformatf("  +%0d", target);
         11:      return $sformatf("\t\v\f%0d", target);
         12:      return "0";
         13:      return "-0";
         14:      return $sformatf("-%0d", $urandom_range(1, 9));
         15:      return $sformatf("%0d", $urandom_range(0, 999));
         16:      return $sformatf("000%0d", target);
         17:      return $sformatf("%0d ", target);
         18:      return "";
         19:      return $sformatf("%0d", $urandom_range(250, 70000));
         default: return $sformatf("%0d", target);
      endcase
   endfunction

   function automatic string lock_text();
      case ($urandom_range(0, 11))
         0, 1, 2: return "0";
         3, 4, 5: return "1";
         6:       return "-0";
         7:       return " +1";
         8:       return $sformatf("%0d", $urandom_range(2, 300));
         9:       return "01";
         10:      return "\t1x";
         default: return "";
      endcase
   endfunction

   // Mostly the keyword itself, now and then a damaged copy of it.
   function automatic string kw_variant(input string good);
      case ($urandom_range(0, 19))
         0:       return good.substr(0, good.len() - 2);
         1:       return {good, "S"};
         2:       return good.tolower();
         3:       return {" ", good};
         default: return good;
      endcase
   endfunction

   // Builds a command line aimed at the given node with random content and
   // occasional damage: a stray byte, an inserted NUL or extra fields.
   function automatic void build_command(input logic [7:0] node);
      int    kind;
      int    spot;
      string head;
      string tail;
      logic  with_lock;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         head = "REQ";
         tail = "PING";
      end else if (kind < 5) begin
         head = "REQ";
         tail = "GET";
      end else if (kind < 9) begin
         head = "SET";
         tail = "LOCK";
      end else begin
         head = $urandom_range(0, 1) ? "REQ" : "SET";
         case ($urandom_range(0, 2))
            0:       tail = "PING";
            1:       tail = "GET";
            default: tail = "LOCK";
         endcase
      end
      with_lock = (head == "SET") || ($urandom_range(0, 3) == 0);
      push_text({kw_variant(head), ",", addr_text(int'(node)), ",", kw_variant(tail)});
      if (with_lock)
         push_text({",", lock_text()});
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 7)) push_text(",z");
      if ($urandom_range(0, 9) == 0)
         push_text(",");
      if ($urandom_range(0, 9) == 0) begin
         spot = $urandom_range(0, line_buf.size() - 1);
         line_buf[spot] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 19) == 0) begin
         spot = $urandom_range(0, line_buf.size() - 1);
         line_buf.insert(spot, rcld_pkg::CHR_NUL);
      end
      end_line();
      // Now and then a second terminator makes an empty line.
      if ($urandom_range(0, 15) == 0)
         end_line();
   endfunction

   // Random traffic: mostly command lines, the rest noise, overlong lines
   // that run straight into a command, and bare terminators.
   task automatic random_phase(input int byte_goal);
      int start;
      int pick;
      start = bytes_sent;
      while (bytes_sent - start < byte_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            build_command(book.node_addr);
         end else if (pick < 90) begin
            repeat ($urandom_range(0, 24)) push_byte(8'($urandom_range(0, 255)));
            end_line();
         end else if (pick < 94) begin
            repeat ($urandom_range(120, 140)) push_byte(8'($urandom_range(32, 126)));
            build_command(book.node_addr);
         end else begin
            end_line();
         end
         send_line();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lines with the reset settings: node 1, servo present.
      send_text_line("REQ,1,PING");
      send_text_line("REQ,0,PING");
      send_text_line("REQ,1,GET");
      // A broadcast poll is not answered.
      send_text_line("REQ,0,GET");
      send_text_line("SET,1,LOCK,1");
      send_text_line("SET,1,LOCK,-0");
      send_text_line("SET,1,LOCK,2");
      // A terminator on an empty line gives no response.
      end_line();
      send_line();
      send_text_line("REQ, \t\v\f+01,PING");
      send_text_line("REQ,-1,PING");
      send_text_line("REQ,300,GET");
      // A NUL cuts the keyword short, so the line does nothing.
      push_text("REQ,1,PI");
      push_byte(rcld_pkg::CHR_NUL);
      push_text("NG");
      send_text_line("");
      // Bytes after a NUL are counted but not decoded.
      push_text("REQ,1,PING");
      push_byte(rcld_pkg::CHR_NUL);
      push_byte(8'hFF);
      send_text_line(",x");
      // More fields than the decoder tracks.
      send_text_line("REQ,1,PING,a,b,c,d,e,f,g,h");
      send_text_line("SET,1,LOCK,1,");
      // An empty first field is a line but not a command.
      send_text_line(",,GET");
      // The byte after a full line overflows it; the line restarts empty.
      repeat (LINE_CAP - 1) push_text("A");
      push_text("B");
      send_text_line("REQ,1,GET");
      settle();

      // Highest address and no servo: broadcast delay is at its maximum and
      // the lock command is ignored. Only bit 0 of the servo write counts.
      write_register(rcld_pkg::CSR_NODE_ADDRESS, 8'd255);
      write_register(rcld_pkg::CSR_SERVO_PRESENT, 8'hFE);
      send_text_line("REQ,0,PING");
      send_text_line("SET,255,LOCK,1");
      send_text_line("REQ,255,GET");
      settle();

      // Node address zero: the broadcast delay saturates at zero.
      write_register(rcld_pkg::CSR_NODE_ADDRESS, 8'd0);
      write_register(rcld_pkg::CSR_SERVO_PRESENT, 8'd1);
      send_text_line("REQ,0,PING");
      send_text_line("REQ,0,GET");
      send_text_line("SET,0,LOCK,0");
      settle();

      // Writes to indexes that hold no register, one with every index bit set.
      write_register(~rcld_pkg::CSR_NODE_ADDRESS, 8'($urandom_range(0, 255)));
      write_register(8'($urandom_range(rcld_pkg::CSR_SERVO_PRESENT + 1, 255)),
                     8'($urandom_range(0, 255)));

      write_register(rcld_pkg::CSR_NODE_ADDRESS, 8'($urandom_range(2, 254)));
      write_register(rcld_pkg::CSR_SERVO_PRESENT, 8'd1);
      random_phase(330);
      settle();

      write_register(rcld_pkg::CSR_NODE_ADDRESS, 8'd255);
      write_register(rcld_pkg::CSR_SERVO_PRESENT, 8'd0);
      random_phase(330);
      settle();

      // A long stretch at full rate on both sides.
      idle_on = 1'b0;
      write_register(rcld_pkg::CSR_NODE_ADDRESS, 8'd1);
      write_register(rcld_pkg::CSR_SERVO_PRESENT, 8'd1);
      random_phase(330);
      settle();
      idle_on = 1'b1;

      write_register(8'($urandom_range(rcld_pkg::CSR_SERVO_PRESENT + 1, 255)),
                     8'($urandom_range(0, 255)));
      write_register(rcld_pkg::CSR_NODE_ADDRESS, 8'($urandom_range(1, 255)));
      write_register(rcld_pkg::CSR_SERVO_PRESENT, 8'($urandom_range(0, 255)));
      random_phase(330);
      settle();

      if (book.failures == 0)
         $display("rs485_command_line_decoder_core_tb: PASS");
      else
         $display("rs485_command_line_decoder_core_tb: FAIL");
      $finish;
   end

   // Guards against a hung handshake; a correct run needs a small part of this.
   initial begin
      #1_000_000;
      $display("rs485_command_line_decoder_core_tb: FAIL");
      $finish;
   end

endmodule
